### src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and helpers for the quaternion to Euler angle core.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STEPS    = 24;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ZFRAC           = 16;

  localparam int CW  = 40;   // cordic x/y width
  localparam int ZW  = 27;   // cordic angle accumulator width
  localparam int SQW = 61;   // isqrt operand width
  localparam int RTW = 31;   // isqrt result width

  localparam int OUT_SH  = ZFRAC - ANGLE_FRAC_BITS;
  localparam int OUT_LIM = 180 * (1 << ANGLE_FRAC_BITS);

  typedef logic signed [CW-1:0] cvec_t;
  typedef logic signed [ZW-1:0] zang_t;

  // atan(2^-i) in degrees * 2^16
  localparam logic [21:0] STEP_ANGLE [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  // multiplier operations
  localparam logic [3:0] MUL_Q1Q1 = 4'd0;
  localparam logic [3:0] MUL_Q2Q2 = 4'd1;
  localparam logic [3:0] MUL_Q3Q3 = 4'd2;
  localparam logic [3:0] MUL_Q2Q3 = 4'd3;
  localparam logic [3:0] MUL_Q0Q1 = 4'd4;
  localparam logic [3:0] MUL_Q1Q2 = 4'd5;
  localparam logic [3:0] MUL_Q0Q3 = 4'd6;
  localparam logic [3:0] MUL_Q3Q1 = 4'd7;
  localparam logic [3:0] MUL_Q0Q2 = 4'd8;
  localparam logic [3:0] MUL_PP   = 4'd9;

  localparam logic [1:0] SEL_ROLL  = 2'd0;
  localparam logic [1:0] SEL_PITCH = 2'd1;
  localparam logic [1:0] SEL_YAW   = 2'd2;

  localparam logic ISQ_Q0 = 1'b0;
  localparam logic ISQ_C  = 1'b1;

  typedef struct packed {
    logic       ld_in;
    logic       mul_en;
    logic [3:0] mul_idx;
    logic       isq_start;
    logic       isq_sel;
    logic       cor_start;
    logic [1:0] cor_sel;
    logic       out_load;
    logic       upd;
    logic       inv;
  } qte_cmd_t;

  typedef struct packed {
    logic use_rec;
    logic norm_bad;
    logic isq_done;
    logic cor_done;
  } qte_sts_t;

  // degrees*2^16 to degrees*2^ANGLE_FRAC_BITS, round half up, clamp
  function automatic logic signed [15:0] to_out(input zang_t z);
    logic signed [ZW:0] r;
    r = ($signed({z[ZW-1], z}) + (ZW+1)'(1 << (OUT_SH - 1))) >>> OUT_SH;
    if (r > (ZW+1)'(OUT_LIM)) r = (ZW+1)'(OUT_LIM);
    if (r < -(ZW+1)'(OUT_LIM)) r = -(ZW+1)'(OUT_LIM);
    return r[15:0];
  endfunction

endpackage

### src/qte_if.sv
// ----------------------------------------------------------------------------
// qte_in_if / qte_out_if
// Valid/ready channels carrying quaternion records and Euler angle results.
// ----------------------------------------------------------------------------
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic               read_ok;
  logic               has_quat;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;

  modport source (output valid, read_ok, has_quat, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, read_ok, has_quat, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               updated;
  logic               norm_invalid;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, updated, norm_invalid,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, updated, norm_invalid,
                  output ready);
endinterface

### src/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [SQW-1:0] arg,
  output logic           done,
  output logic [RTW-1:0] res
);

  logic [SQW-1:0] v_r, v_nxt;
  logic [SQW:0]   res_r, res_nxt;
  logic [SQW-1:0] bit_r;
  logic [SQW:0]   trial;
  logic           busy_r;
  logic           done_r;

  always_comb begin
    trial = res_r + {1'b0, bit_r};
    if ({1'b0, v_r} >= trial) begin
      v_nxt   = v_r - trial[SQW-1:0];
      res_nxt = (res_r >> 1) + {1'b0, bit_r};
    end else begin
      v_nxt   = v_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= arg;
      res_r <= '0;
      bit_r <= SQW'(1) << (SQW - 1);
    end else if (busy_r) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign res  = res_r[RTW-1:0];

endmodule

### src/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Iterative vectoring CORDIC giving atan2 in degrees * 2^16.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  cvec_t y_in,
  input  cvec_t x_in,
  output logic  done,
  output zang_t z_out
);

  localparam zang_t Z90  = zang_t'(90 << ZFRAC);
  localparam zang_t Z180 = zang_t'(180 << ZFRAC);

  cvec_t      x_r, y_r, dx, dy;
  zang_t      z_r, za;
  logic [4:0] i_r;
  logic       busy_r;
  logic       done_r;
  logic       last;

  assign dx   = y_r >>> i_r;
  assign dy   = x_r >>> i_r;
  assign za   = zang_t'(STEP_ANGLE[i_r]);
  assign last = (i_r == 5'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= (y_in != '0);
        done_r <= (y_in == '0);
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r <= '0;
      if (y_in == '0) begin
        z_r <= x_in[CW-1] ? Z180 : '0;
        x_r <= x_in;
        y_r <= y_in;
      end else if (x_in[CW-1] && !y_in[CW-1]) begin
        x_r <= y_in;
        y_r <= -x_in;
        z_r <= Z90;
      end else if (x_in[CW-1]) begin
        x_r <= -y_in;
        y_r <= x_in;
        z_r <= -Z90;
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= '0;
      end
    end else if (busy_r) begin
      i_r <= i_r + 5'd1;
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + za;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - za;
      end
    end
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule

### src/qte_datapath.sv
// ----------------------------------------------------------------------------
// qte_datapath
// Shared multiplier, product accumulators, isqrt and CORDIC units, angle regs.
// ----------------------------------------------------------------------------
module qte_datapath import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  qte_cmd_t           cmd,
  output qte_sts_t           sts,
  input  logic               read_ok,
  input  logic               has_quat,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               updated,
  output logic               norm_invalid
);

  localparam logic [63:0]    ONE64 = 64'(1) << 60;
  localparam logic [SQW-1:0] ONE61 = SQW'(1) << 60;
  localparam logic signed [63:0] T2_LIM = 64'sd1 << 59;

  logic signed [31:0] qx_r, qy_r, qz_r;
  logic               use_r;
  logic [RTW-1:0]     q0_r, c_r;

  logic signed [32:0] ma, mb, q0s, qxs, qys, qzs, ps;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod_r;
  logic               acc_vld_r;
  logic [3:0]         acc_idx_r;

  logic [63:0]        s_r;
  logic [62:0]        sq1_r, sq2_r, sq3_r;
  logic [SQW-1:0]     pp_r;
  logic signed [63:0] t0_r, t2_r, t3_r;

  logic signed [63:0] t2c, t1, t4;
  logic [63:0]        sum12, sum23;
  logic signed [31:0] p;

  logic [SQW-1:0] isq_arg;
  logic [RTW-1:0] isq_res;
  logic           isq_done;
  cvec_t          cy, cx;
  zang_t          cz;
  logic           cor_done;
  logic signed [15:0] cz_ang;

  logic signed [15:0] new_roll_r, new_yaw_r, held_roll_r, held_yaw_r;
  logic signed [14:0] new_pitch_r, held_pitch_r;
  logic signed [15:0] out_roll_r, out_yaw_r;
  logic signed [14:0] out_pitch_r;
  logic               out_upd_r, out_inv_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      qx_r  <= quat_x;
      qy_r  <= quat_y;
      qz_r  <= quat_z;
      use_r <= read_ok & has_quat;
    end
  end

  // pitch sine, clamped, in Q30
  always_comb begin
    t2c = t2_r;
    if (t2_r > T2_LIM) t2c = T2_LIM;
    if (t2_r < -T2_LIM) t2c = -T2_LIM;
    p = 32'(t2c >>> 29);
  end

  assign q0s = $signed({2'b00, q0_r});
  assign qxs = {qx_r[31], qx_r};
  assign qys = {qy_r[31], qy_r};
  assign qzs = {qz_r[31], qz_r};
  assign ps  = {p[31], p};

  always_comb begin
    unique case (cmd.mul_idx)
      MUL_Q1Q1: begin ma = qxs; mb = qxs; end
      MUL_Q2Q2: begin ma = qys; mb = qys; end
      MUL_Q3Q3: begin ma = qzs; mb = qzs; end
      MUL_Q2Q3: begin ma = qys; mb = qzs; end
      MUL_Q0Q1: begin ma = q0s; mb = qxs; end
      MUL_Q1Q2: begin ma = qxs; mb = qys; end
      MUL_Q0Q3: begin ma = q0s; mb = qzs; end
      MUL_Q3Q1: begin ma = qzs; mb = qxs; end
      MUL_Q0Q2: begin ma = q0s; mb = qys; end
      MUL_PP:   begin ma = ps;  mb = ps;  end
      default:  begin ma = '0;  mb = '0;  end
    endcase
  end

  assign mul_full = ma * mb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_full[63:0];
    acc_idx_r <= cmd.mul_idx;
    if (acc_vld_r) begin
      unique case (acc_idx_r)
        MUL_Q1Q1: begin sq1_r <= prod_r[62:0]; s_r <= prod_r; end
        MUL_Q2Q2: begin sq2_r <= prod_r[62:0]; s_r <= s_r + prod_r; end
        MUL_Q3Q3: begin sq3_r <= prod_r[62:0]; s_r <= s_r + prod_r; end
        MUL_Q2Q3: t0_r <= prod_r;
        MUL_Q0Q1: t0_r <= t0_r + prod_r;
        MUL_Q1Q2: t3_r <= prod_r;
        MUL_Q0Q3: t3_r <= t3_r + prod_r;
        MUL_Q3Q1: t2_r <= -prod_r;
        MUL_Q0Q2: t2_r <= t2_r + prod_r;
        MUL_PP:   pp_r <= prod_r[SQW-1:0];
        default: ;
      endcase
    end
  end

  assign isq_arg = (cmd.isq_sel == ISQ_C) ? (ONE61 - pp_r) : (ONE61 - s_r[SQW-1:0]);

  qte_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.isq_start),
    .arg   (isq_arg),
    .done  (isq_done),
    .res   (isq_res)
  );

  always_ff @(posedge clk) begin
    if (isq_done) begin
      if (cmd.isq_sel == ISQ_C) c_r <= isq_res;
      else                      q0_r <= isq_res;
    end
  end

  assign sum12 = {1'b0, sq1_r} + {1'b0, sq2_r};
  assign sum23 = {1'b0, sq2_r} + {1'b0, sq3_r};
  assign t1    = $signed(ONE64 - (sum12 << 1));
  assign t4    = $signed(ONE64 - (sum23 << 1));

  always_comb begin
    unique case (cmd.cor_sel)
      SEL_ROLL: begin
        cy = CW'(t0_r >>> 29);
        cx = CW'(t1 >>> 30);
      end
      SEL_PITCH: begin
        cy = CW'(p);
        cx = CW'({1'b0, c_r});
      end
      default: begin
        cy = CW'(t3_r >>> 29);
        cx = CW'(t4 >>> 30);
      end
    endcase
  end

  qte_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cor_start),
    .y_in  (cy),
    .x_in  (cx),
    .done  (cor_done),
    .z_out (cz)
  );

  assign cz_ang = to_out(cz);

  always_ff @(posedge clk) begin
    if (cor_done) begin
      unique case (cmd.cor_sel)
        SEL_ROLL:  new_roll_r  <= cz_ang;
        SEL_PITCH: new_pitch_r <= cz_ang[14:0];
        default:   new_yaw_r   <= cz_ang;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_roll_r  <= '0;
      held_pitch_r <= '0;
      held_yaw_r   <= '0;
    end else if (cmd.out_load && cmd.upd) begin
      held_roll_r  <= new_roll_r;
      held_pitch_r <= new_pitch_r;
      held_yaw_r   <= new_yaw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_roll_r  <= cmd.upd ? new_roll_r  : held_roll_r;
      out_pitch_r <= cmd.upd ? new_pitch_r : held_pitch_r;
      out_yaw_r   <= cmd.upd ? new_yaw_r   : held_yaw_r;
      out_upd_r   <= cmd.upd;
      out_inv_r   <= cmd.inv;
    end
  end

  assign sts.use_rec  = use_r;
  assign sts.norm_bad = (s_r > ONE64);
  assign sts.isq_done = isq_done;
  assign sts.cor_done = cor_done;

  assign roll_angle   = out_roll_r;
  assign pitch_angle  = out_pitch_r;
  assign yaw_angle    = out_yaw_r;
  assign updated      = out_upd_r;
  assign norm_invalid = out_inv_r;

endmodule

### src/qte_ctrl.sv
// ----------------------------------------------------------------------------
// qte_ctrl
// Sequencer for one record: squares, isqrt, cross products, CORDIC, result.
// ----------------------------------------------------------------------------
module qte_ctrl import qte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output qte_cmd_t cmd,
  input  qte_sts_t sts
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_SQ     = 5'd2;
  localparam logic [4:0] S_SQD    = 5'd3;
  localparam logic [4:0] S_CHK    = 5'd4;
  localparam logic [4:0] S_ISQ0   = 5'd5;
  localparam logic [4:0] S_ISQ0W  = 5'd6;
  localparam logic [4:0] S_PR     = 5'd7;
  localparam logic [4:0] S_PRD    = 5'd8;
  localparam logic [4:0] S_PP     = 5'd9;
  localparam logic [4:0] S_PPD    = 5'd10;
  localparam logic [4:0] S_ISQ1   = 5'd11;
  localparam logic [4:0] S_ISQ1W  = 5'd12;
  localparam logic [4:0] S_CROLL  = 5'd13;
  localparam logic [4:0] S_CROLLW = 5'd14;
  localparam logic [4:0] S_CPIT   = 5'd15;
  localparam logic [4:0] S_CPITW  = 5'd16;
  localparam logic [4:0] S_CYAW   = 5'd17;
  localparam logic [4:0] S_CYAWW  = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [3:0] mcnt_r, mcnt_nxt;
  logic       upd_r, upd_nxt;
  logic       inv_r, inv_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    mcnt_nxt  = mcnt_r;
    upd_nxt   = upd_r;
    inv_nxt   = inv_r;
    cmd       = '0;
    cmd.mul_idx = mcnt_r;
    cmd.upd     = upd_r;
    cmd.inv     = inv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          upd_nxt   = 1'b0;
          inv_nxt   = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        mcnt_nxt  = MUL_Q1Q1;
        state_nxt = sts.use_rec ? S_SQ : S_DONE;
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        mcnt_nxt   = mcnt_r + 4'd1;
        if (mcnt_r == MUL_Q3Q3) state_nxt = S_SQD;
      end
      S_SQD: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.norm_bad) begin
          inv_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ISQ0;
        end
      end
      S_ISQ0: begin
        cmd.isq_start = 1'b1;
        cmd.isq_sel   = ISQ_Q0;
        state_nxt     = S_ISQ0W;
      end
      S_ISQ0W: begin
        cmd.isq_sel = ISQ_Q0;
        if (sts.isq_done) begin
          mcnt_nxt  = MUL_Q2Q3;
          state_nxt = S_PR;
        end
      end
      S_PR: begin
        cmd.mul_en = 1'b1;
        mcnt_nxt   = mcnt_r + 4'd1;
        if (mcnt_r == MUL_Q0Q2) state_nxt = S_PRD;
      end
      S_PRD: begin
        mcnt_nxt  = MUL_PP;
        state_nxt = S_PP;
      end
      S_PP: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_PPD;
      end
      S_PPD: state_nxt = S_ISQ1;
      S_ISQ1: begin
        cmd.isq_start = 1'b1;
        cmd.isq_sel   = ISQ_C;
        state_nxt     = S_ISQ1W;
      end
      S_ISQ1W: begin
        cmd.isq_sel = ISQ_C;
        if (sts.isq_done) state_nxt = S_CROLL;
      end
      S_CROLL: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel   = SEL_ROLL;
        state_nxt     = S_CROLLW;
      end
      S_CROLLW: begin
        cmd.cor_sel = SEL_ROLL;
        if (sts.cor_done) state_nxt = S_CPIT;
      end
      S_CPIT: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel   = SEL_PITCH;
        state_nxt     = S_CPITW;
      end
      S_CPITW: begin
        cmd.cor_sel = SEL_PITCH;
        if (sts.cor_done) state_nxt = S_CYAW;
      end
      S_CYAW: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel   = SEL_YAW;
        state_nxt     = S_CYAWW;
      end
      S_CYAWW: begin
        cmd.cor_sel = SEL_YAW;
        if (sts.cor_done) begin
          upd_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcnt_r      <= '0;
      upd_r       <= 1'b0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      upd_r       <= upd_nxt;
      inv_r       <= inv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd_r && inv_r))
    else $error("updated and norm_invalid both set");

  a_isq_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.isq_done |-> (state_r == S_ISQ0W || state_r == S_ISQ1W))
    else $error("isqrt finished outside a wait state");

  a_cor_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.cor_done |-> (state_r == S_CROLLW || state_r == S_CPITW || state_r == S_CYAWW))
    else $error("cordic finished outside a wait state");

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted beat not dispatched");

endmodule

### src/quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Quaternion vector part to roll / pitch / yaw in 1/128 degree.
//
//   channel  dir  payload                                               
//   in_bus   in   read_ok, has_quat, quat_x, quat_y, quat_z (Q30)        
//   out_bus  out  roll_angle, pitch_angle, yaw_angle, updated, norm_invalid
//
// A used record runs two 31-step isqrt passes and three 24-step CORDIC passes
// on one shared unit each, plus ten multiplies on one 33x33 multiplier. Unused
// records skip all of these; non-unit records stop after the three squares.
// One record at a time; a full output register holds the core in its last
// state until the pending beat is taken.
// rst_n is synchronous; held angles reset to 0.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core import qte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  qte_in_if.sink           in_bus,
  qte_out_if.source        out_bus
);

  qte_cmd_t cmd;
  qte_sts_t sts;

  qte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  qte_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .read_ok      (in_bus.read_ok),
    .has_quat     (in_bus.has_quat),
    .quat_x       (in_bus.quat_x),
    .quat_y       (in_bus.quat_y),
    .quat_z       (in_bus.quat_z),
    .roll_angle   (out_bus.roll_angle),
    .pitch_angle  (out_bus.pitch_angle),
    .yaw_angle    (out_bus.yaw_angle),
    .updated      (out_bus.updated),
    .norm_invalid (out_bus.norm_invalid)
  );

endmodule

### tb/quaternion_to_euler_angles_core_test.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core_test
// Drives quaternion records through the core with bursty input and a stalling
// output, predicts roll / pitch / yaw with a bit-exact CORDIC model and checks
// every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class euler_scoreboard;
  logic signed [15:0] held_roll, held_yaw;
  logic signed [14:0] held_pitch;
  logic signed [15:0] exp_roll[$], exp_yaw[$];
  logic signed [14:0] exp_pitch[$];
  logic exp_upd[$], exp_inv[$];
  int mismatches;

  function new();
    held_roll = 0; held_pitch = 0; held_yaw = 0; mismatches = 0;
  endfunction

  static function longint asr(longint v, int k);
    return v >>> k;
  endfunction

  static function longint isqrt(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return longint'(res);
  endfunction

  static function longint atan2_deg(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? (longint'(180) << qte_pkg::ZFRAC) : 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(90) << qte_pkg::ZFRAC;
      end else begin
        t = x; x = -y; y = t; z = -(longint'(90) << qte_pkg::ZFRAC);
      end
    end
    for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(qte_pkg::STEP_ANGLE[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(qte_pkg::STEP_ANGLE[i]);
      end
    end
    return z;
  endfunction

  static function longint scale_angle(longint z);
    longint r, lim;
    lim = 180 * (1 << qte_pkg::ANGLE_FRAC_BITS);
    r = (z + (longint'(1) << (qte_pkg::OUT_SH - 1))) >>> qte_pkg::OUT_SH;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function void note_record(logic rok, logic hq, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] zq);
    longint q1, q2, q3, q0, t0, t1, t2, t3, t4, p, c, one;
    longint unsigned s;
    logic upd, inv;
    upd = 0; inv = 0;
    one = longint'(1) << 60;
    if (rok && hq) begin
      q1 = x; q2 = y; q3 = zq;
      s = longint'(q1 * q1) + longint'(q2 * q2) + longint'(q3 * q3);
      if (s > longint'(one)) begin
        inv = 1;
      end else begin
        q0 = isqrt(one - s);
        t0 = 2 * (q0 * q1 + q2 * q3);
        t1 = one - 2 * (q1 * q1 + q2 * q2);
        t2 = 2 * (q0 * q2 - q3 * q1);
        t3 = 2 * (q0 * q3 + q1 * q2);
        t4 = one - 2 * (q2 * q2 + q3 * q3);
        if (t2 > one) t2 = one;
        if (t2 < -one) t2 = -one;
        p = t2 >>> 30;
        c = isqrt(one - p * p);
        held_roll = 16'(scale_angle(atan2_deg(t0 >>> 30, t1 >>> 30)));
        held_pitch = 15'(scale_angle(atan2_deg(p, c)));
        held_yaw = 16'(scale_angle(atan2_deg(t3 >>> 30, t4 >>> 30)));
        upd = 1;
      end
    end
    exp_roll.push_back(held_roll);
    exp_pitch.push_back(held_pitch);
    exp_yaw.push_back(held_yaw);
    exp_upd.push_back(upd);
    exp_inv.push_back(inv);
  endfunction

  function void check_angles(logic signed [15:0] r, logic signed [14:0] p,
                             logic signed [15:0] yw, logic u, logic n);
    logic signed [15:0] er, ey;
    logic signed [14:0] ep;
    logic eu, en;
    if (exp_roll.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat r=%0d p=%0d y=%0d", r, p, yw);
      return;
    end
    er = exp_roll.pop_front(); ep = exp_pitch.pop_front(); ey = exp_yaw.pop_front();
    eu = exp_upd.pop_front(); en = exp_inv.pop_front();
    if (r !== er || p !== ep || yw !== ey || u !== eu || n !== en) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp r=%0d p=%0d y=%0d u=%b n=%b got r=%0d p=%0d y=%0d u=%b n=%b",
                 er, ep, ey, eu, en, r, p, yw, u, n);
    end
  endfunction

  function int pending();
    return exp_roll.size();
  endfunction
endclass

module quaternion_to_euler_angles_core_test;
  import qte_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  qte_in_if in_bus();
  qte_out_if out_bus();
  euler_scoreboard angles = new();
  longint cycles = 0;
  bit long_hold = 0;
  bit hold_req = 0;

  quaternion_to_euler_angles_core uut (.clk(clk), .rst_n(rst_n), .in_bus(in_bus),
                                       .out_bus(out_bus));

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_bus.valid = 0; in_bus.read_ok = 0; in_bus.has_quat = 0;
    in_bus.quat_x = 0; in_bus.quat_y = 0; in_bus.quat_z = 0;
    out_bus.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      angles.note_record(in_bus.read_ok, in_bus.has_quat, in_bus.quat_x, in_bus.quat_y,
                         in_bus.quat_z);
    if (rst_n && out_bus.valid && out_bus.ready)
      angles.check_angles(out_bus.roll_angle, out_bus.pitch_angle, out_bus.yaw_angle,
                          out_bus.updated, out_bus.norm_invalid);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 0;
        repeat (1500) @(posedge clk);
        hold_req = 0;
        long_hold = 1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        case (mode)
          0: out_bus.ready <= 1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          2: out_bus.ready <= $urandom_range(0, 1);
          default: out_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_record(logic rok, logic hq, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
    in_bus.valid <= 1;
    in_bus.read_ok <= rok; in_bus.has_quat <= hq;
    in_bus.quat_x <= x; in_bus.quat_y <= y; in_bus.quat_z <= z;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    in_bus.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // random signed vector component, magnitude limited to lim_bits signed bits
  function automatic logic [31:0] rnd_comp(int lim_bits);
    logic signed [31:0] v;
    v = $signed($urandom) >>> (32 - lim_bits);
    return v;
  endfunction

  task automatic send_random();
    int kind, b;
    kind = $urandom_range(0, 19);
    b = $urandom_range(20, 30);
    case (kind)
      0: send_record($urandom_range(0, 1), 0, $urandom, $urandom, $urandom);
      1: send_record(0, 1, $urandom, $urandom, $urandom);
      2, 3: send_record(1, 1, $urandom, $urandom, $urandom);
      4: send_record(1, 1, rnd_comp(b) , 0, 0);
      5: send_record(1, 1, 0, rnd_comp(b), 0);
      6: send_record(1, 1, 0, 0, rnd_comp(b));
      default: send_record(1, 1, rnd_comp(b), rnd_comp(b), rnd_comp(b));
    endcase
  endtask

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] HALF_Q30 = 32'h2000_0000;

  initial begin
    int sent;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_record(1, 1, 0, 0, 0);
    send_record(0, 1, ONE_Q30, 0, 0);
    send_record(1, 0, 0, ONE_Q30, 0);
    send_record(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(1, 1, ONE_Q30, 0, 0);
    send_record(1, 1, 0, ONE_Q30, 0);
    send_record(1, 1, 0, 0, ONE_Q30);
    send_record(1, 1, -ONE_Q30, 0, 0);
    send_record(1, 1, 0, -ONE_Q30, 0);
    send_record(1, 1, 0, 0, -ONE_Q30);
    send_record(1, 1, ONE_Q30 + 1, 0, 0);
    send_record(1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_record(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_record(1, 1, HALF_Q30, HALF_Q30, HALF_Q30);
    send_record(1, 1, HALF_Q30, -HALF_Q30, HALF_Q30);
    send_record(1, 1, 32'h2D41_3CCD, 32'h2D41_3CCD, 0);
    send_record(1, 1, 0, 32'h2D41_3CCD, 32'h2D41_3CCD);
    send_record(1, 1, 32'h2D41_3CCD, 0, 32'h2D41_3CCD);
    send_record(1, 1, HALF_Q30, HALF_Q30, HALF_Q30 + 32'h1000_0000);
    send_record(1, 1, 1, 32'hFFFF_FFFF, 1);
    // sender pause until drained
    in_bus.valid <= 0;
    while (angles.pending() != 0) @(posedge clk);
    // keep offering while the receiver holds off
    hold_req = 1;
    while (!long_hold) send_random();
    sent = 0;
    while (sent < 1600) begin
      repeat ($urandom_range(1, 12)) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 200));
    end
    in_bus.valid <= 0;
    while (angles.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (angles.mismatches == 0 && angles.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
